// ===== sv/rar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types, constants and helper functions of the rational arithmetic
// reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int FIELD_W   = 32;

    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [2*WORD_BITS-1:0] t_dword;
    typedef logic [FIELD_W-1:0]     t_field;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        t_word   a;
        t_word   b;
    } t_alu_req;

    typedef struct packed {
        logic   done;
        t_dword prod;
        t_word  quo;
        t_word  rem;
    } t_alu_rsp;

    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_fix;

    function automatic t_word to_word(input t_field x);
        logic [63:0] ext;
        ext = 64'(signed'(x));
        return ext[WORD_BITS-1:0];
    endfunction

    function automatic t_field to_field(input t_word v);
        logic [63:0] ext;
        ext = 64'(signed'(v));
        return ext[FIELD_W-1:0];
    endfunction

    function automatic t_word mag(input t_word v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Signed wrap of a magnitude product, with range check.
    function automatic t_fix mul_fix(input t_dword p, input logic neg);
        t_fix  f;
        t_word lo;
        logic  hi_set;
        lo     = p[WORD_BITS-1:0];
        hi_set = |p[2*WORD_BITS-1:WORD_BITS];
        f.val  = neg ? (~lo + 1'b1) : lo;
        if (neg) begin
            f.ovf = hi_set || (lo[WORD_BITS-1] && (|lo[WORD_BITS-2:0]));
        end else begin
            f.ovf = hi_set || lo[WORD_BITS-1];
        end
        return f;
    endfunction

    // Signed wrap of a magnitude quotient.
    function automatic t_fix quo_fix(input t_word q, input logic neg);
        t_fix f;
        f.val = neg ? (~q + 1'b1) : q;
        f.ovf = !neg && q[WORD_BITS-1];
        return f;
    endfunction

endpackage

// ===== sv/rar_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_alu
// Shared iterative unit: shift-add multiply of two magnitudes, or
// align/subtract divide giving quotient and remainder, on one adder.
// ----------------------------------------------------------------------------
module rar_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rar_pkg::t_alu_req i_req,
    output rar_pkg::t_alu_rsp o_rsp
);
    import rar_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ALIGN,
        S_REDUCE
    } t_state;

    t_state           r_state;
    logic             r_done;
    t_word            r_hi;
    t_word            r_lo;
    t_word            r_b;
    t_word            r_a;
    t_word            r_q;
    logic [CNT_W-1:0] r_cnt;

    t_word              add_x;
    t_word              add_y;
    logic               add_sub;
    logic [WORD_BITS:0] sum;
    logic               carry;

    always_comb begin
        unique case (r_state)
            S_MUL: begin
                add_x   = r_hi;
                add_y   = r_lo[0] ? r_b : '0;
                add_sub = 1'b0;
            end
            S_ALIGN: begin
                add_x   = r_a >> 1;
                add_y   = r_b;
                add_sub = 1'b1;
            end
            default: begin
                add_x   = r_a;
                add_y   = r_b;
                add_sub = 1'b1;
            end
        endcase
        sum   = {1'b0, add_x} + {1'b0, add_y ^ {WORD_BITS{add_sub}}}
                + (WORD_BITS+1)'(add_sub);
        carry = sum[WORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_b <= i_req.b;
                        if (i_req.op == ALU_MUL) begin
                            r_hi    <= '0;
                            r_lo    <= i_req.a;
                            r_cnt   <= CNT_W'(WORD_BITS - 1);
                            r_state <= S_MUL;
                        end else begin
                            r_a     <= i_req.a;
                            r_q     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_ALIGN;
                        end
                    end
                end
                S_MUL: begin
                    r_hi <= sum[WORD_BITS:1];
                    r_lo <= {sum[0], r_lo[WORD_BITS-1:1]};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_ALIGN: begin
                    if (carry) begin
                        r_b   <= r_b << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (carry) begin
                        r_a <= sum[WORD_BITS-1:0];
                    end
                    r_q <= {r_q[WORD_BITS-2:0], carry};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_b   <= r_b >> 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo};
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_a;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("request while unit busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("done while still iterating");

endmodule

// ===== sv/rational_arith_reduce_top.sv =====
`timescale 1ns / 1ps
// Steps: two or three products on the shared unit, then one divide per Euclid remainder
//   and two scaling divides.
// Throughput: one item at a time; s_axis_tready is high only while idle.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// rational_arith_reduce_top
// Rational add/subtract/multiply/divide with reduction by Euclid's common
// divisor, sequenced over one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_num, left_den, right_num, right_den
    input  logic [127:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_num, result_den
    output logic [63:0]  m_axis_tdata,
    // wrapped, undefined
    output logic [1:0]   m_axis_tuser
);
    import rar_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_D,
        S_COMBINE,
        S_PREP,
        S_GCD,
        S_FINISH_G,
        S_SCALE_N,
        S_SCALE_D,
        S_OUT
    } t_state;

    t_state   r_state;
    t_alu_req r_req;
    t_alu_rsp alu_rsp;

    t_cmd   r_cmd;
    t_word  r_ln;
    t_word  r_ld;
    t_word  r_rn;
    t_word  r_rd;
    t_word  r_n;
    t_word  r_t;
    t_word  r_d;
    t_word  r_mn;
    t_word  r_md;
    t_word  r_ga;
    t_word  r_gb;
    logic   r_par;
    logic   r_gneg;
    logic   r_pneg;
    logic   r_qneg;
    logic   r_wrap;
    logic   r_undef;
    t_field r_out_num;
    t_field r_out_den;
    logic   r_tvalid;

    t_fix  mf;
    t_fix  qf;
    t_word comb_n;
    logic  comb_ovf;
    t_word in_ln;
    t_word in_rn;
    t_word in_rd;
    t_word mul_x_b;
    t_word mul_d_b;

    rar_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        mf    = mul_fix(alu_rsp.prod, r_pneg);
        qf    = quo_fix(alu_rsp.quo, r_qneg);
        in_ln = to_word(s_axis_tdata[31:0]);
        in_rn = to_word(s_axis_tdata[95:64]);
        in_rd = to_word(s_axis_tdata[127:96]);
        mul_x_b = (t_cmd'(s_axis_tuser) == CMD_MUL) ? in_rn : in_rd;
        mul_d_b = (r_cmd == CMD_DIV) ? r_rn : r_rd;
        if (r_cmd == CMD_SUB) begin
            comb_n   = r_n - r_t;
            comb_ovf = (r_n[WORD_BITS-1] != r_t[WORD_BITS-1])
                       && (comb_n[WORD_BITS-1] != r_n[WORD_BITS-1]);
        end else begin
            comb_n   = r_n + r_t;
            comb_ovf = (r_n[WORD_BITS-1] == r_t[WORD_BITS-1])
                       && (comb_n[WORD_BITS-1] != r_n[WORD_BITS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_req     <= '0;
            r_tvalid  <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd       <= t_cmd'(s_axis_tuser);
                        r_ln        <= in_ln;
                        r_ld        <= to_word(s_axis_tdata[63:32]);
                        r_rn        <= in_rn;
                        r_rd        <= in_rd;
                        r_wrap      <= 1'b0;
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_MUL;
                        r_req.a     <= mag(in_ln);
                        r_req.b     <= mag(mul_x_b);
                        r_pneg      <= in_ln[WORD_BITS-1] ^ mul_x_b[WORD_BITS-1];
                        r_state     <= S_MUL_X;
                    end
                end
                S_MUL_X: begin
                    if (alu_rsp.done) begin
                        r_n         <= mf.val;
                        r_wrap      <= r_wrap | mf.ovf;
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_MUL;
                        if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                            r_req.a <= mag(r_rn);
                            r_req.b <= mag(r_ld);
                            r_pneg  <= r_rn[WORD_BITS-1] ^ r_ld[WORD_BITS-1];
                            r_state <= S_MUL_Y;
                        end else begin
                            r_req.a <= mag(r_ld);
                            r_req.b <= mag(mul_d_b);
                            r_pneg  <= r_ld[WORD_BITS-1] ^ mul_d_b[WORD_BITS-1];
                            r_state <= S_MUL_D;
                        end
                    end
                end
                S_MUL_Y: begin
                    if (alu_rsp.done) begin
                        r_t         <= mf.val;
                        r_wrap      <= r_wrap | mf.ovf;
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_MUL;
                        r_req.a     <= mag(r_ld);
                        r_req.b     <= mag(r_rd);
                        r_pneg      <= r_ld[WORD_BITS-1] ^ r_rd[WORD_BITS-1];
                        r_state     <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (alu_rsp.done) begin
                        r_d     <= mf.val;
                        r_wrap  <= r_wrap | mf.ovf;
                        r_state <= S_COMBINE;
                    end
                end
                S_COMBINE: begin
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_n    <= comb_n;
                        r_wrap <= r_wrap | comb_ovf;
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_mn  <= mag(r_n);
                    r_md  <= mag(r_d);
                    r_ga  <= mag(r_n);
                    r_gb  <= mag(r_d);
                    r_par <= 1'b0;
                    if (r_d == '0) begin
                        r_state <= S_FINISH_G;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_DIV;
                        r_req.a     <= mag(r_n);
                        r_req.b     <= mag(r_d);
                        r_state     <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (alu_rsp.done) begin
                        r_ga  <= r_gb;
                        r_gb  <= alu_rsp.rem;
                        r_par <= ~r_par;
                        if (alu_rsp.rem == '0) begin
                            r_state <= S_FINISH_G;
                        end else begin
                            r_req.start <= 1'b1;
                            r_req.op    <= ALU_DIV;
                            r_req.a     <= r_gb;
                            r_req.b     <= alu_rsp.rem;
                        end
                    end
                end
                S_FINISH_G: begin
                    if (r_ga == '0) begin
                        r_undef   <= 1'b1;
                        r_out_num <= '0;
                        r_out_den <= '0;
                        r_tvalid  <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_undef     <= 1'b0;
                        r_gneg      <= r_par ? r_d[WORD_BITS-1] : r_n[WORD_BITS-1];
                        r_qneg      <= r_n[WORD_BITS-1] ^
                                       (r_par ? r_d[WORD_BITS-1] : r_n[WORD_BITS-1]);
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_DIV;
                        r_req.a     <= r_mn;
                        r_req.b     <= r_ga;
                        r_state     <= S_SCALE_N;
                    end
                end
                S_SCALE_N: begin
                    if (alu_rsp.done) begin
                        r_out_num   <= to_field(qf.val);
                        r_wrap      <= r_wrap | qf.ovf;
                        r_qneg      <= r_d[WORD_BITS-1] ^ r_gneg;
                        r_req.start <= 1'b1;
                        r_req.op    <= ALU_DIV;
                        r_req.a     <= r_md;
                        r_req.b     <= r_ga;
                        r_state     <= S_SCALE_D;
                    end
                end
                S_SCALE_D: begin
                    if (alu_rsp.done) begin
                        r_out_den <= to_field(qf.val);
                        r_wrap    <= r_wrap | qf.ovf;
                        r_tvalid  <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_tvalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = {r_out_den, r_out_num};
    assign m_axis_tuser  = {r_undef, r_wrap};

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while result pending");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_MUL_X || r_state == S_MUL_Y ||
                          r_state == S_MUL_D || r_state == S_GCD ||
                          r_state == S_SCALE_N || r_state == S_SCALE_D))
        else $error("unit done outside a waiting step");

    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |=> !r_req.start)
        else $error("start held longer than one cycle");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("undefined result not zero");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] && m_axis_tdata[63:32] == '0
        |-> m_axis_tdata[31:0] == 32'd1)
        else $error("zero denominator without unit numerator");

endmodule

// ===== tb/tb_rational_arith_reduce_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce_top
// Streams pairs of signed fractions with a command through the rational
// reduce block under random source gaps and sink stalls. Each item is scored
// against a local predictor of the cross products, Euclid reduction and the
// wrap and undefined flags.
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce_top;
    import rar_pkg::*;

    localparam int     NUM_RANDOM  = 400;
    localparam int     TAIL_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 2_000_000;

    localparam t_field MAX_POS = 32'h7fff_ffff;
    localparam t_field MAX_NEG = 32'h8000_0000;
    localparam t_field ONE     = 32'd1;
    localparam t_field NEG_ONE = 32'hffff_ffff;
    localparam t_field ZERO    = 32'd0;

    typedef struct {
        t_cmd   op;
        t_field ln;
        t_field ld;
        t_field rn;
        t_field rd;
    } t_operands;

    typedef struct packed {
        t_field num;
        t_field den;
        logic   wrapped;
        logic   undefined;
    } t_fraction;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // left_num, left_den, right_num, right_den
    logic [127:0] s_axis_tdata  = '0;
    // command
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // result_num, result_den
    logic [63:0]  m_axis_tdata;
    // wrapped, undefined
    logic [1:0]   m_axis_tuser;

    t_operands   pending[$];
    t_fraction   expected_fracs[$];
    int          total_items = 0;
    int          taken_items = 0;
    int          errors      = 0;
    longint      cycles      = 0;
    bit          item_taken  = 1'b0;
    bit          frac_taken  = 1'b0;
    int unsigned send_wait   = 0;
    int unsigned recv_wait   = 2;
    bit          send_calm   = 1'b0;
    bit          recv_calm   = 1'b0;

    rational_arith_reduce_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sx32(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic bit spills(input longint v);
        return v != sx32(v[31:0]);
    endfunction

    function automatic t_fraction reduce_fraction(input t_cmd op, input t_field ln,
                                                  input t_field ld, input t_field rn,
                                                  input t_field rd);
        longint    a, b, n, d, x, y, r, q;
        t_fraction f;
        f = '0;
        case (op)
            CMD_MUL: begin
                n = sx32(ln) * sx32(rn);
                d = sx32(ld) * sx32(rd);
            end
            CMD_DIV: begin
                n = sx32(ln) * sx32(rd);
                d = sx32(ld) * sx32(rn);
            end
            default: begin
                a = sx32(ln) * sx32(rd);
                b = sx32(rn) * sx32(ld);
                d = sx32(ld) * sx32(rd);
                f.wrapped = spills(a) || spills(b) || spills(d);
                a = sx32(a[31:0]);
                b = sx32(b[31:0]);
                n = (op == CMD_ADD) ? a + b : a - b;
            end
        endcase
        f.wrapped = f.wrapped || spills(n) || spills(d);
        n = sx32(n[31:0]);
        d = sx32(d[31:0]);

        x = n;
        y = d;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end

        if (x == 0) begin
            f.undefined = 1'b1;
        end else begin
            q = n / x;
            f.wrapped = f.wrapped || spills(q);
            f.num = q[31:0];
            q = d / x;
            f.wrapped = f.wrapped || spills(q);
            f.den = q[31:0];
        end
        return f;
    endfunction

    function automatic t_field draw_part();
        case ($urandom_range(0, 9))
            0:       return ZERO;
            1, 2:    return $urandom();
            3:       return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(0, 64) - 32;
        endcase
    endfunction

    task automatic queue_ops(input t_cmd op, input t_field ln, input t_field ld,
                             input t_field rn, input t_field rd);
        t_operands ops;
        ops.op = op;
        ops.ln = ln;
        ops.ld = ld;
        ops.rn = rn;
        ops.rd = rd;
        pending.push_back(ops);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, what, signed'(want), signed'(got));
            errors++;
        end
    endtask

    // source side
    always @(negedge i_clk) begin
        t_operands ops;
        if (item_taken) begin
            if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 5);
        end
        if (i_rst_n && (!s_axis_tvalid || item_taken)) begin
            if (send_wait > 0) begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                ops = pending.pop_front();
                s_axis_tdata  <= {ops.rd, ops.rn, ops.ld, ops.ln};
                s_axis_tuser  <= ops.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(negedge i_clk) begin
        if (m_axis_tvalid && recv_wait > 0) recv_wait--;
        if (frac_taken) begin
            if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 5);
        end
        m_axis_tready <= i_rst_n && (recv_wait == 0);
    end

    always @(posedge i_clk) begin
        t_fraction got;
        t_fraction want;
        cycles     <= cycles + 1;
        item_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        frac_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_fracs.push_back(reduce_fraction(t_cmd'(s_axis_tuser),
                                                     s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32],
                                                     s_axis_tdata[95:64],
                                                     s_axis_tdata[127:96]));
            taken_items <= taken_items + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.num       = m_axis_tdata[31:0];
            got.den       = m_axis_tdata[63:32];
            got.wrapped   = m_axis_tuser[0];
            got.undefined = m_axis_tuser[1];
            if (expected_fracs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d flags %b",
                         $time, signed'(got.num), signed'(got.den), m_axis_tuser);
                errors++;
            end else begin
                want = expected_fracs.pop_front();
                check_field("result_num", want.num, got.num);
                check_field("result_den", want.den, got.den);
                check_field("wrapped", 32'(want.wrapped), 32'(got.wrapped));
                check_field("undefined", 32'(want.undefined), 32'(got.undefined));
            end
        end
    end

    initial begin
        queue_ops(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        queue_ops(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        queue_ops(CMD_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
        queue_ops(CMD_DIV, 32'd2, 32'd3, 32'd4, 32'd5);
        queue_ops(CMD_MUL, ZERO, ZERO, 32'd5, 32'd7);
        queue_ops(CMD_ADD, ZERO, ZERO, ZERO, ZERO);
        queue_ops(CMD_DIV, ONE, 32'd2, ZERO, ONE);
        queue_ops(CMD_ADD, 32'd3, ZERO, ZERO, ONE);
        queue_ops(CMD_DIV, ONE, 32'd2, ZERO, 32'd5);
        queue_ops(CMD_MUL, MAX_NEG, NEG_ONE, ONE, ONE);
        queue_ops(CMD_DIV, MAX_NEG, ONE, ONE, NEG_ONE);
        queue_ops(CMD_ADD, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
        queue_ops(CMD_SUB, MAX_NEG, ONE, ONE, ONE);
        queue_ops(CMD_SUB, MAX_POS, ONE, NEG_ONE, ONE);
        queue_ops(CMD_MUL, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        queue_ops(CMD_DIV, MAX_POS, ONE, MAX_NEG, ONE);
        queue_ops(CMD_MUL, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
        queue_ops(CMD_MUL, -32'sd3, -32'sd6, 32'd4, 32'd10);
        queue_ops(CMD_ADD, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE);
        queue_ops(CMD_SUB, 32'd7, -32'sd14, 32'd5, 32'd9);
        queue_ops(CMD_DIV, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
        queue_ops(CMD_ADD, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            queue_ops(t_cmd'($urandom_range(0, 3)), draw_part(), draw_part(),
                      draw_part(), draw_part());
        end
        total_items = pending.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(taken_items == total_items && expected_fracs.size() == 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout: expected %0d items, %0d accepted, %0d results pending",
                     $time, total_items, taken_items, expected_fracs.size());
            errors++;
        end

        if (errors == 0) begin
            $display("tb_rational_arith_reduce_top: clean");
        end else begin
            $display("tb_rational_arith_reduce_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rar_pkg.sv
sv/rar_alu.sv
sv/rational_arith_reduce_top.sv
tb/tb_rational_arith_reduce_top.sv
